// File: hdl/kef_pkg.sv
// Shared types and constants for the key event frame transmitter.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package kef_pkg;

	// Register map of the configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TICKS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SETUP_TICKS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TICKS      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_TICKS       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTE_GAP_TICKS  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP_TICKS = 3'd7;

	// Reset values of the registers.
	localparam logic [6:0] RST_DEVICE_ADDRESS  = 7'h42;
	localparam logic [7:0] RST_IDLE_TICKS      = 8'd5;
	localparam logic [7:0] RST_HOLD_TICKS      = 8'd3;
	localparam logic [7:0] RST_SETUP_TICKS     = 8'd1;
	localparam logic [7:0] RST_HIGH_TICKS      = 8'd2;
	localparam logic [7:0] RST_LOW_TICKS       = 8'd2;
	localparam logic [7:0] RST_BYTE_GAP_TICKS  = 8'd2;
	localparam logic [7:0] RST_FRAME_GAP_TICKS = 8'd20;

	typedef struct packed {
		logic [6:0] device_address;
		logic [7:0] idle_ticks;
		logic [7:0] hold_ticks;
		logic [7:0] setup_ticks;
		logic [7:0] high_ticks;
		logic [7:0] low_ticks;
		logic [7:0] byte_gap_ticks;
		logic [7:0] frame_gap_ticks;
	} cfg_t;

	// Which timing registers are nonzero; a zero-length phase is skipped.
	typedef struct packed {
		logic setup;
		logic high;
		logic low;
		logic hold;
		logic byte_gap;
		logic frame_gap;
	} nz_t;

	typedef enum logic [3:0] {
		PH_READY      = 4'd0,
		PH_IDLE       = 4'd1,
		PH_START_HOLD = 4'd2,
		PH_START_LOW  = 4'd3,
		PH_BIT_SETUP  = 4'd4,
		PH_BIT_HIGH   = 4'd5,
		PH_BIT_LOW    = 4'd6,
		PH_ACK_SETUP  = 4'd7,
		PH_ACK_HIGH   = 4'd8,
		PH_ACK_LOW    = 4'd9,
		PH_BYTE_GAP   = 4'd10,
		PH_STOP_PREP  = 4'd11,
		PH_STOP_HIGH  = 4'd12,
		PH_STOP_HOLD  = 4'd13,
		PH_FRAME_GAP  = 4'd14
	} phase_t;

endpackage

`default_nettype wire

// File: hdl/key_event_frame_transmitter_top.sv
// Top level of the key event frame transmitter: stream ports, input register,
// configuration registers and the bus sequencer. Depends on kef_pkg and all modules.
`default_nettype none

// The block sends one open-drain, I2C-style write frame per accepted key
// report: the device address with write bit zero, then the key state and the
// difference against the previously reported state, each MSB first. Every
// input transfer is either a tick, which moves the bus waveform one step on,
// or a report, which starts a frame only when no frame or frame gap is in
// progress and is otherwise dropped. Every input transfer yields exactly one
// output transfer carrying the clock and data line levels, the busy flag and
// whether that report started a frame. The block takes one transfer per clock
// cycle when the output side keeps up; a result is registered first in the
// input register and then in the phase sequencer, which finds the next phase
// of nonzero length combinationally even when several phases in a row are
// configured to zero ticks. A stalled output holds the pipeline, and the input
// register still takes one more transfer while a result waits. The user must
// write configuration only while the block is idle; the block does not enforce
// it. Configuration is written one register per transfer on the configuration
// channel, which never stalls.
module key_event_frame_transmitter_top #(
	parameter int STATE_BITS = 16,
	parameter int DATA_BYTES = 4
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// Input stream.
	input  wire                                  s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire  [((STATE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // key_state
	input  wire  [0:0]                           s_axis_tuser,  // func
	// Result stream.
	output logic                                 m_axis_tvalid,
	input  wire                                  m_axis_tready,
	output logic [7:0]                           m_axis_tdata,  // scl_level,
	                                                            // sda_level, busy_res,
	                                                            // accepted, zero pad
	// Configuration write channel.
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [kef_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [kef_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import kef_pkg::*;

	cfg_t                  cfg;
	logic                  valid_s1;
	logic                  func_s1;
	logic [STATE_BITS-1:0] key_s1;
	logic                  core_ready;
	logic                  scl, sda, busy, acc;

	// Register writes complete in the cycle they are offered.
	assign cfg_ready = 1'b1;

	kef_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Input register: it refills whenever it is empty or the core takes it.
	assign s_axis_tready = !valid_s1 || core_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			func_s1 <= s_axis_tuser[0];
			key_s1  <= s_axis_tdata[STATE_BITS-1:0];
		end
	end

	kef_core #(
		.STATE_BITS (STATE_BITS),
		.DATA_BYTES (DATA_BYTES)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (valid_s1),
		.in_ready     (core_ready),
		.in_func      (func_s1),
		.in_key       (key_s1),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_scl      (scl),
		.out_sda      (sda),
		.out_busy     (busy),
		.out_accepted (acc)
	);

	assign m_axis_tdata = {4'b0000, acc, busy, sda, scl};

endmodule

`default_nettype wire

// File: hdl/kef_cfg_regs.sv
// Configuration register file of the key event frame transmitter.
// Depends on kef_pkg for the register map and reset values.
`default_nettype none

module kef_cfg_regs (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                wr_valid,
	input  wire  [kef_pkg::CFG_IDX_W-1:0]      wr_index,
	input  wire  [kef_pkg::CFG_DATA_W-1:0]     wr_data,
	output kef_pkg::cfg_t                      cfg
);
	import kef_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address  <= RST_DEVICE_ADDRESS;
			cfg_q.idle_ticks      <= RST_IDLE_TICKS;
			cfg_q.hold_ticks      <= RST_HOLD_TICKS;
			cfg_q.setup_ticks     <= RST_SETUP_TICKS;
			cfg_q.high_ticks      <= RST_HIGH_TICKS;
			cfg_q.low_ticks       <= RST_LOW_TICKS;
			cfg_q.byte_gap_ticks  <= RST_BYTE_GAP_TICKS;
			cfg_q.frame_gap_ticks <= RST_FRAME_GAP_TICKS;
		end else if (wr_valid) begin
			case (wr_index)
				CFG_DEVICE_ADDRESS:  cfg_q.device_address  <= wr_data[6:0];
				CFG_IDLE_TICKS:      cfg_q.idle_ticks      <= wr_data;
				CFG_HOLD_TICKS:      cfg_q.hold_ticks      <= wr_data;
				CFG_SETUP_TICKS:     cfg_q.setup_ticks     <= wr_data;
				CFG_HIGH_TICKS:      cfg_q.high_ticks      <= wr_data;
				CFG_LOW_TICKS:       cfg_q.low_ticks       <= wr_data;
				CFG_BYTE_GAP_TICKS:  cfg_q.byte_gap_ticks  <= wr_data;
				CFG_FRAME_GAP_TICKS: cfg_q.frame_gap_ticks <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: hdl/kef_advance.sv
// Next-phase search of the bus sequencer: finds the next phase that lasts at
// least one tick, skipping zero-length phases in closed form. Depends on kef_pkg.
`default_nettype none

module kef_advance #(
	parameter  int DATA_BYTES = 4,
	localparam int KW         = $clog2(DATA_BYTES + 1)
) (
	input  kef_pkg::phase_t  cur_phase,
	input  wire  [2:0]       cur_bit,
	input  wire  [KW-1:0]    cur_byte,
	input  kef_pkg::nz_t     nz,
	output kef_pkg::phase_t  nxt_phase,
	output logic [2:0]       nxt_bit,
	output logic [KW-1:0]    nxt_byte
);
	import kef_pkg::*;

	localparam logic [KW-1:0] LAST_BYTE = KW'(DATA_BYTES);

	typedef struct packed {
		phase_t        ph;
		logic [2:0]    b;
		logic [KW-1:0] k;
	} step_t;

	// Clock cell position codes: 2'd0 setup, 2'd1 high, 2'd2 low, 2'd3 past the cell.
	function automatic logic cell_has(input logic [1:0] from, input nz_t n);
		return (from == 2'd0 && (n.setup || n.high || n.low)) ||
		       (from == 2'd1 && (n.high || n.low)) ||
		       (from == 2'd2 && n.low);
	endfunction

	function automatic logic [1:0] cell_first(input logic [1:0] from, input nz_t n);
		if (from == 2'd0 && n.setup)
			return 2'd0;
		else if (from <= 2'd1 && n.high)
			return 2'd1;
		else
			return 2'd2;
	endfunction

	function automatic phase_t bit_phase(input logic [1:0] pos);
		case (pos)
			2'd0:    return PH_BIT_SETUP;
			2'd1:    return PH_BIT_HIGH;
			default: return PH_BIT_LOW;
		endcase
	endfunction

	function automatic phase_t ack_phase(input logic [1:0] pos);
		case (pos)
			2'd0:    return PH_ACK_SETUP;
			2'd1:    return PH_ACK_HIGH;
			default: return PH_ACK_LOW;
		endcase
	endfunction

	// Stop sequence positions: 0 prep, 1 high, 2 hold, 3 frame gap.
	function automatic step_t stop_from(input logic [1:0] from, input nz_t n,
			input logic [2:0] b, input logic [KW-1:0] k);
		step_t r;
		r.b = b;
		r.k = k;
		if (from == 2'd0 && n.low)
			r.ph = PH_STOP_PREP;
		else if (from <= 2'd1 && n.high)
			r.ph = PH_STOP_HIGH;
		else if (from <= 2'd2 && n.hold)
			r.ph = PH_STOP_HOLD;
		else if (n.frame_gap)
			r.ph = PH_FRAME_GAP;
		else
			r.ph = PH_READY;
		return r;
	endfunction

	// Leaving the byte gap: next byte, or the stop sequence after the last.
	function automatic step_t after_gap(input nz_t n, input logic [2:0] b,
			input logic [KW-1:0] k);
		step_t r;
		if (k < LAST_BYTE) begin
			if (n.setup || n.high || n.low)
				r = '{bit_phase(cell_first(2'd0, n)), 3'd0, KW'(k + 1'b1)};
			else if (n.byte_gap)
				r = '{PH_BYTE_GAP, 3'd7, KW'(k + 1'b1)};
			else
				r = stop_from(2'd0, n, 3'd7, LAST_BYTE);
		end else begin
			r = stop_from(2'd0, n, b, k);
		end
		return r;
	endfunction

	function automatic step_t after_ack(input logic [1:0] from, input nz_t n,
			input logic [2:0] b, input logic [KW-1:0] k);
		step_t r;
		if (cell_has(from, n))
			r = '{ack_phase(cell_first(from, n)), b, k};
		else if (n.byte_gap)
			r = '{PH_BYTE_GAP, b, k};
		else
			r = after_gap(n, b, k);
		return r;
	endfunction

	// When every clock cell phase is zero, the remaining bits pass at once
	// and the bit index ends at seven, as the ack slot is skipped too.
	function automatic step_t after_bit(input logic [1:0] from, input nz_t n,
			input logic [2:0] b, input logic [KW-1:0] k);
		step_t r;
		if (cell_has(from, n))
			r = '{bit_phase(cell_first(from, n)), b, k};
		else if (b < 3'd7 && (n.setup || n.high || n.low))
			r = '{bit_phase(cell_first(2'd0, n)), 3'(b + 1'b1), k};
		else
			r = after_ack(2'd0, n, 3'd7, k);
		return r;
	endfunction

	step_t r;

	always_comb begin
		case (cur_phase)
			PH_IDLE: begin
				if (nz.hold)
					r = '{PH_START_HOLD, cur_bit, cur_byte};
				else if (nz.low)
					r = '{PH_START_LOW, cur_bit, cur_byte};
				else
					r = after_bit(2'd0, nz, cur_bit, cur_byte);
			end
			PH_START_HOLD: begin
				if (nz.low)
					r = '{PH_START_LOW, cur_bit, cur_byte};
				else
					r = after_bit(2'd0, nz, cur_bit, cur_byte);
			end
			PH_START_LOW: r = after_bit(2'd0, nz, cur_bit, cur_byte);
			PH_BIT_SETUP: r = after_bit(2'd1, nz, cur_bit, cur_byte);
			PH_BIT_HIGH:  r = after_bit(2'd2, nz, cur_bit, cur_byte);
			PH_BIT_LOW:   r = after_bit(2'd3, nz, cur_bit, cur_byte);
			PH_ACK_SETUP: r = after_ack(2'd1, nz, cur_bit, cur_byte);
			PH_ACK_HIGH:  r = after_ack(2'd2, nz, cur_bit, cur_byte);
			PH_ACK_LOW:   r = after_ack(2'd3, nz, cur_bit, cur_byte);
			PH_BYTE_GAP:  r = after_gap(nz, cur_bit, cur_byte);
			PH_STOP_PREP: r = stop_from(2'd1, nz, cur_bit, cur_byte);
			PH_STOP_HIGH: r = stop_from(2'd2, nz, cur_bit, cur_byte);
			PH_STOP_HOLD: r = stop_from(2'd3, nz, cur_bit, cur_byte);
			default:      r = '{PH_READY, cur_bit, cur_byte};
		endcase
	end

	assign nxt_phase = r.ph;
	assign nxt_bit   = r.b;
	assign nxt_byte  = r.k;

endmodule

`default_nettype wire

// File: hdl/kef_core.sv
// Sequencer state, frame latch and result register of the transmitter.
// Depends on kef_pkg and kef_advance.
`default_nettype none

module kef_core #(
	parameter int STATE_BITS = 16,
	parameter int DATA_BYTES = 4
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  kef_pkg::cfg_t          cfg,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire                    in_func,
	input  wire  [STATE_BITS-1:0]  in_key,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic                   out_scl,
	output logic                   out_sda,
	output logic                   out_busy,
	output logic                   out_accepted
);
	import kef_pkg::*;

	localparam int KW  = $clog2(DATA_BYTES + 1);
	localparam int FW  = 2 * STATE_BITS;
	localparam int DW  = 8 * DATA_BYTES;
	localparam int FRW = DW + 8;
	localparam logic [KW-1:0] LAST_BYTE = KW'(DATA_BYTES);

	phase_t                phase_q;
	logic [7:0]            ticks_q;
	logic [2:0]            bit_q;
	logic [KW-1:0]         byte_q;
	logic [STATE_BITS-1:0] last_q;
	logic [FRW-1:0]        frame_q;
	logic                  valid_q;
	logic                  scl_q, sda_q, busy_q, acc_q;

	nz_t                   nz;
	logic                  step;
	logic                  do_start;
	logic                  do_adv;
	phase_t                src_phase;
	logic [2:0]            src_bit;
	logic [KW-1:0]         src_byte;
	phase_t                adv_phase;
	logic [2:0]            adv_bit;
	logic [KW-1:0]         adv_byte;
	logic [FW-1:0]         word;
	logic [DW-1:0]         data_word;
	phase_t                phase_n;
	logic [7:0]            ticks_n;
	logic [2:0]            bit_n;
	logic [KW-1:0]         byte_n;
	logic [FRW-1:0]        frame_n;
	logic [7:0]            cur_byte;
	logic                  data_bit;
	logic                  scl_n, sda_n;

	function automatic logic [7:0] phase_length(input cfg_t c, input phase_t p);
		case (p)
			PH_IDLE:                   return c.idle_ticks;
			PH_START_HOLD, PH_STOP_HOLD: return c.hold_ticks;
			PH_START_LOW, PH_BIT_LOW, PH_ACK_LOW, PH_STOP_PREP:
				return c.low_ticks;
			PH_BIT_SETUP, PH_ACK_SETUP: return c.setup_ticks;
			PH_BIT_HIGH, PH_ACK_HIGH, PH_STOP_HIGH: return c.high_ticks;
			PH_BYTE_GAP:               return c.byte_gap_ticks;
			PH_FRAME_GAP:              return c.frame_gap_ticks;
			default:                   return 8'd0;
		endcase
	endfunction

	assign nz.setup     = |cfg.setup_ticks;
	assign nz.high      = |cfg.high_ticks;
	assign nz.low       = |cfg.low_ticks;
	assign nz.hold      = |cfg.hold_ticks;
	assign nz.byte_gap  = |cfg.byte_gap_ticks;
	assign nz.frame_gap = |cfg.frame_gap_ticks;

	assign in_ready = !valid_q || out_ready;
	assign step     = in_valid && in_ready;

	// A report only starts a frame from ready; a tick only moves a live frame.
	assign do_start = in_func && (phase_q == PH_READY);
	assign do_adv   = in_func ? (do_start && (cfg.idle_ticks == 8'd0))
	                          : ((phase_q != PH_READY) && (ticks_q <= 8'd1));

	assign src_phase = in_func ? PH_IDLE : phase_q;
	assign src_bit   = in_func ? 3'd0 : bit_q;
	assign src_byte  = in_func ? '0 : byte_q;

	kef_advance #(
		.DATA_BYTES (DATA_BYTES)
	) u_advance (
		.cur_phase (src_phase),
		.cur_bit   (src_bit),
		.cur_byte  (src_byte),
		.nz        (nz),
		.nxt_phase (adv_phase),
		.nxt_bit   (adv_bit),
		.nxt_byte  (adv_byte)
	);

	// Data bytes: the key state above the difference word, MSB first.
	assign word = {in_key, in_key ^ last_q};

	generate
		if (DW > FW) begin : g_pad
			assign data_word = {{(DW - FW){1'b0}}, word};
		end else begin : g_cut
			assign data_word = word[DW-1:0];
		end
	endgenerate

	always_comb begin
		phase_n = phase_q;
		ticks_n = ticks_q;
		bit_n   = bit_q;
		byte_n  = byte_q;
		frame_n = frame_q;
		if (do_start) begin
			frame_n = {cfg.device_address, 1'b0, data_word};
		end
		if (do_adv) begin
			phase_n = adv_phase;
			ticks_n = phase_length(cfg, adv_phase);
			bit_n   = adv_bit;
			byte_n  = adv_byte;
		end else if (do_start) begin
			phase_n = PH_IDLE;
			ticks_n = cfg.idle_ticks;
			bit_n   = 3'd0;
			byte_n  = '0;
		end else if (!in_func && phase_q != PH_READY) begin
			ticks_n = ticks_q - 8'd1;
		end
	end

	always_comb begin
		cur_byte = 8'd0;
		for (int j = 0; j <= DATA_BYTES; j++) begin
			if (byte_n == KW'(j))
				cur_byte = frame_n[(DATA_BYTES - j) * 8 +: 8];
		end
	end

	assign data_bit = cur_byte[3'd7 - bit_n];

	always_comb begin
		case (phase_n)
			PH_START_LOW, PH_BIT_SETUP, PH_BIT_LOW, PH_ACK_SETUP, PH_ACK_LOW,
			PH_BYTE_GAP, PH_STOP_PREP:
				scl_n = 1'b0;
			default:
				scl_n = 1'b1;
		endcase
		case (phase_n)
			PH_START_HOLD, PH_START_LOW, PH_STOP_PREP, PH_STOP_HIGH:
				sda_n = 1'b0;
			PH_BIT_SETUP, PH_BIT_HIGH, PH_BIT_LOW:
				sda_n = data_bit;
			default:
				sda_n = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_READY;
			ticks_q <= 8'd0;
			bit_q   <= 3'd0;
			byte_q  <= '0;
			last_q  <= '1;
			valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q <= phase_n;
				ticks_q <= ticks_n;
				bit_q   <= bit_n;
				byte_q  <= byte_n;
				if (do_start)
					last_q <= in_key;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			frame_q <= frame_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			busy_q  <= (phase_n != PH_READY);
			acc_q   <= do_start;
		end
	end

	assign out_valid    = valid_q;
	assign out_scl      = scl_q;
	assign out_sda      = sda_q;
	assign out_busy     = busy_q;
	assign out_accepted = acc_q;

`ifndef NO_ASSERTIONS
	// Only the ready phase may have no ticks left; every live phase has one.
	a_ticks_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_READY) == (ticks_q == 8'd0))
		else $error("tick count disagrees with phase");

	// The byte index never passes the last data byte.
	a_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_q <= LAST_BYTE)
		else $error("byte index out of range");

	// A report that arrives mid-frame leaves the stored key state alone.
	a_busy_report: assert property (@(posedge clk) disable iff (!arst_n)
		(step && in_func && phase_q != PH_READY) |=> $stable(last_q))
		else $error("report taken while busy");

	// A report that starts a frame reports the bus as busy.
	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_accepted) |-> out_busy)
		else $error("frame started but not busy");
`endif

endmodule

`default_nettype wire
